/* hdl/tssb_pkg.sv */
package tssb_pkg;

	// Fixed field widths of the stream and config channels
	localparam int DEST_W      = 8;
	localparam int IDX_W       = 4;
	localparam int PKG_W       = 16;
	localparam int STATUS_W    = 3;
	localparam int USED_W      = 3;
	localparam int MASK_W      = 8;
	localparam int LIVE_W      = 4;
	localparam int TAG_SLOTS   = 8;
	localparam int TAG_SLOT_W  = 8;
	localparam int TAGS_W      = TAG_SLOTS * TAG_SLOT_W;
	localparam int IN_TUSER_W  = 1;
	localparam int IN_TDATA_W  = 32;
	localparam int OUT_TDATA_W = 32;
	localparam int CFG_IDX_W   = 1;
	localparam int CFG_DATA_W  = 64;

	// Parameter defaults
	localparam int DEF_MAX_SECTIONS = 8;
	localparam int DEF_STACK_DEPTH  = 64;
	localparam int DEF_TAG_BITS     = 8;

	typedef enum logic {
		OP_STORE    = 1'b0,
		OP_RETRIEVE = 1'b1
	} op_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK        = 3'd0,
		ST_NO_MATCH  = 3'd1,
		ST_BAD_INDEX = 3'd2,
		ST_EMPTY     = 3'd3,
		ST_FULL      = 3'd4
	} status_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_ACTIVE_SECTIONS = 1'b0,
		REG_SECTION_TAGS    = 1'b1
	} cfg_reg_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_EXEC,
		S_WB
	} state_t;

	// Command to the fill counter bank
	typedef struct packed {
		logic commit;   // apply the step to the selected counter
		logic up;       // 1 push (increment), 0 pop (decrement)
	} fill_cmd_t;

endpackage

/* hdl/tssb_mem.sv */
module tssb_mem #(
	parameter int ADDR_W = 9,
	parameter int DATA_W = 16
) (
	input  logic              clk,
	input  logic              we,
	input  logic              re,
	input  logic [ADDR_W-1:0] addr,
	input  logic [DATA_W-1:0] wdata,
	output logic [DATA_W-1:0] rdata
);

	logic [DATA_W-1:0] mem [2**ADDR_W];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		if (re) begin
			rdata <= mem[addr];
		end
	end

endmodule

/* hdl/tssb_tag_match.sv */
module tssb_tag_match #(
	parameter int MAX_SECTIONS = tssb_pkg::DEF_MAX_SECTIONS,
	parameter int TAG_BITS     = tssb_pkg::DEF_TAG_BITS,
	parameter int SEC_W        = 3
) (
	input  logic [tssb_pkg::TAGS_W-1:0] tags,
	input  logic [tssb_pkg::LIVE_W-1:0] live,
	input  logic [tssb_pkg::DEST_W-1:0] destination,
	output logic                        hit,
	output logic [SEC_W-1:0]            hit_sec
);

	// Priority match: scan downward so the lowest matching section wins
	always_comb begin
		hit     = 1'b0;
		hit_sec = '0;
		for (int i = MAX_SECTIONS - 1; i >= 0; i--) begin
			if ((tssb_pkg::LIVE_W'(i) < live) &&
			    (tssb_pkg::DEST_W'(tags[i*tssb_pkg::TAG_SLOT_W +: TAG_BITS]) == destination)) begin
				hit     = 1'b1;
				hit_sec = SEC_W'(i);
			end
		end
	end

endmodule

/* hdl/tssb_fill.sv */
module tssb_fill #(
	parameter int MAX_SECTIONS = tssb_pkg::DEF_MAX_SECTIONS,
	parameter int SEC_W        = 3,
	parameter int FILL_W       = 7,
	parameter int PTR_W        = 6
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  tssb_pkg::fill_cmd_t     cmd,
	input  logic [SEC_W-1:0]        sel,
	output logic [FILL_W-1:0]       sel_fill,
	output logic [PTR_W-1:0]        ptr,
	output logic [MAX_SECTIONS-1:0] empty_vec
);

	logic [FILL_W-1:0] fill_q [MAX_SECTIONS];
	logic [FILL_W-1:0] step;

	always_comb begin
		sel_fill = '0;
		for (int i = 0; i < MAX_SECTIONS; i++) begin
			if (sel == SEC_W'(i)) begin
				sel_fill = fill_q[i];
			end
		end
	end

	// Shared up/down unit: push writes at fill, pop reads at fill-1
	assign step = cmd.up ? sel_fill + FILL_W'(1) : sel_fill - FILL_W'(1);
	assign ptr  = cmd.up ? sel_fill[PTR_W-1:0] : step[PTR_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < MAX_SECTIONS; i++) begin
				fill_q[i] <= '0;
			end
		end else if (cmd.commit) begin
			for (int i = 0; i < MAX_SECTIONS; i++) begin
				if (sel == SEC_W'(i)) begin
					fill_q[i] <= step;
				end
			end
		end
	end

	always_comb begin
		for (int i = 0; i < MAX_SECTIONS; i++) begin
			empty_vec[i] = (fill_q[i] == '0);
		end
	end

endmodule

/* hdl/tagged_section_stack_bank.sv */
// Channel   Dir  Handshake                  Payload
// s_axis    in   s_axis_tvalid/tready       op (tuser), destination, section_index, package_in
// m_axis    out  m_axis_tvalid/tready       status, package_out, section_used, empty_mask
// cfg       in   cfg_valid/cfg_ready        cfg_index, cfg_data (always ready)
//
// Each transaction runs an execute state, which matches the tag, checks the fill
// counter and issues the stack memory access, then a writeback state, in which the
// registered read data lands in the output register. The single memory port and the
// shared fill up/down unit serialise the transactions; the next item is taken in
// writeback. A stalled output holds the block in writeback.
// Reset clears fill counters, config and control; stack memory has no reset.
module tagged_section_stack_bank #(
	parameter int MAX_SECTIONS = tssb_pkg::DEF_MAX_SECTIONS,
	parameter int STACK_DEPTH  = tssb_pkg::DEF_STACK_DEPTH,
	parameter int TAG_BITS     = tssb_pkg::DEF_TAG_BITS
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             s_axis_tvalid,
	output logic                             s_axis_tready,
	// [0] op
	input  logic [tssb_pkg::IN_TUSER_W-1:0]  s_axis_tuser,
	// [7:0] destination, [11:8] section_index, [27:12] package_in
	input  logic [tssb_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
	output logic                             m_axis_tvalid,
	input  logic                             m_axis_tready,
	// [2:0] status, [18:3] package_out, [21:19] section_used, [29:22] empty_mask
	output logic [tssb_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [tssb_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [tssb_pkg::CFG_DATA_W-1:0]  cfg_data
);

	localparam int SEC_W  = (MAX_SECTIONS > 1) ? $clog2(MAX_SECTIONS) : 1;
	localparam int PTR_W  = $clog2(STACK_DEPTH);
	localparam int FILL_W = $clog2(STACK_DEPTH + 1);
	localparam int ADDR_W = SEC_W + PTR_W;

	// Config registers
	logic [tssb_pkg::LIVE_W-1:0] active_q;
	logic [tssb_pkg::TAGS_W-1:0] tags_q;
	logic [tssb_pkg::LIVE_W-1:0] live;

	// Captured input transaction
	tssb_pkg::op_t               op_q;
	logic [tssb_pkg::DEST_W-1:0] dest_q;
	logic [tssb_pkg::IDX_W-1:0]  idx_q;
	logic [tssb_pkg::PKG_W-1:0]  pkg_q;

	// Result held from execute to writeback
	tssb_pkg::status_t status_q;
	logic [SEC_W-1:0]  used_q;
	logic              pop_q;

	tssb_pkg::state_t state_q, state_d;

	logic in_acc, out_free;
	logic m_valid_q;
	logic [tssb_pkg::OUT_TDATA_W-1:0] m_data_q;

	// Datapath
	logic                    hit;
	logic [SEC_W-1:0]        hit_sec;
	logic [SEC_W-1:0]        sec;
	logic [FILL_W-1:0]       sel_fill;
	logic [PTR_W-1:0]        ptr;
	logic [MAX_SECTIONS-1:0] empty_vec;
	tssb_pkg::fill_cmd_t     fill_cmd;
	tssb_pkg::status_t       status_d;
	logic                    mem_we, mem_re;
	logic [tssb_pkg::PKG_W-1:0] rdata;
	logic [tssb_pkg::MASK_W-1:0] empty_mask;
	logic [tssb_pkg::PKG_W-1:0]  pkg_out;
	logic                        bad_idx, full, is_empty;

	assign cfg_ready = 1'b1;
	assign live = (active_q > tssb_pkg::LIVE_W'(MAX_SECTIONS)) ?
	              tssb_pkg::LIVE_W'(MAX_SECTIONS) : active_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= '0;
			tags_q   <= '0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				tssb_pkg::REG_ACTIVE_SECTIONS: active_q <= cfg_data[tssb_pkg::LIVE_W-1:0];
				tssb_pkg::REG_SECTION_TAGS:    tags_q   <= cfg_data;
				default: ;
			endcase
		end
	end

	assign out_free      = !m_valid_q || m_axis_tready;
	assign s_axis_tready = (state_q == tssb_pkg::S_IDLE) ||
	                       ((state_q == tssb_pkg::S_WB) && out_free);
	assign in_acc        = s_axis_tvalid && s_axis_tready;

	always_ff @(posedge clk) begin
		if (in_acc) begin
			op_q   <= tssb_pkg::op_t'(s_axis_tuser[0]);
			dest_q <= s_axis_tdata[7:0];
			idx_q  <= s_axis_tdata[11:8];
			pkg_q  <= s_axis_tdata[27:12];
		end
	end

	tssb_tag_match #(
		.MAX_SECTIONS (MAX_SECTIONS),
		.TAG_BITS     (TAG_BITS),
		.SEC_W        (SEC_W)
	) u_match (
		.tags        (tags_q),
		.live        (live),
		.destination (dest_q),
		.hit         (hit),
		.hit_sec     (hit_sec)
	);

	tssb_fill #(
		.MAX_SECTIONS (MAX_SECTIONS),
		.SEC_W        (SEC_W),
		.FILL_W       (FILL_W),
		.PTR_W        (PTR_W)
	) u_fill (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (fill_cmd),
		.sel       (sec),
		.sel_fill  (sel_fill),
		.ptr       (ptr),
		.empty_vec (empty_vec)
	);

	// Decode of the captured transaction; only acts in the execute cycle
	always_comb begin
		bad_idx  = (idx_q >= live);
		full     = (sel_fill == FILL_W'(STACK_DEPTH));
		is_empty = (sel_fill == '0);
		fill_cmd = '0;
		mem_we   = 1'b0;
		mem_re   = 1'b0;
		status_d = tssb_pkg::ST_OK;
		if (op_q == tssb_pkg::OP_STORE) begin
			sec         = hit_sec;
			fill_cmd.up = 1'b1;
			if (!hit) begin
				status_d = tssb_pkg::ST_NO_MATCH;
			end else if (full) begin
				status_d = tssb_pkg::ST_FULL;
			end
		end else begin
			sec = idx_q[SEC_W-1:0];
			if (bad_idx) begin
				status_d = tssb_pkg::ST_BAD_INDEX;
			end else if (is_empty) begin
				status_d = tssb_pkg::ST_EMPTY;
			end
		end
		if (state_q == tssb_pkg::S_EXEC && status_d == tssb_pkg::ST_OK) begin
			fill_cmd.commit = 1'b1;
			mem_we = (op_q == tssb_pkg::OP_STORE);
			mem_re = (op_q == tssb_pkg::OP_RETRIEVE);
		end
	end

	tssb_mem #(
		.ADDR_W (ADDR_W),
		.DATA_W (tssb_pkg::PKG_W)
	) u_mem (
		.clk   (clk),
		.we    (mem_we),
		.re    (mem_re),
		.addr  ({sec, ptr}),
		.wdata (pkg_q),
		.rdata (rdata)
	);

	always_ff @(posedge clk) begin
		if (state_q == tssb_pkg::S_EXEC) begin
			status_q <= status_d;
			pop_q    <= mem_re;
			used_q   <= (status_d == tssb_pkg::ST_NO_MATCH ||
			             status_d == tssb_pkg::ST_BAD_INDEX) ? '0 : sec;
		end
	end

	// Empty mask after the fill update, inactive sections read zero
	always_comb begin
		empty_mask = '0;
		for (int i = 0; i < MAX_SECTIONS; i++) begin
			empty_mask[i] = (tssb_pkg::LIVE_W'(i) < live) && empty_vec[i];
		end
	end

	assign pkg_out = pop_q ? rdata : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= tssb_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			tssb_pkg::S_IDLE: begin
				if (in_acc) begin
					state_d = tssb_pkg::S_EXEC;
				end
			end
			tssb_pkg::S_EXEC: state_d = tssb_pkg::S_WB;
			tssb_pkg::S_WB: begin
				if (out_free) begin
					state_d = in_acc ? tssb_pkg::S_EXEC : tssb_pkg::S_IDLE;
				end
			end
			default: state_d = tssb_pkg::S_IDLE;
		endcase
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (state_q == tssb_pkg::S_WB && out_free) begin
			m_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == tssb_pkg::S_WB && out_free) begin
			m_data_q <= {2'b00, empty_mask, tssb_pkg::USED_W'(used_q), pkg_out, status_q};
		end
	end

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = m_data_q;

	// Every accepted transaction runs execute then writeback
	a_accept_exec: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc |=> (state_q == tssb_pkg::S_EXEC))
		else $error("accepted transaction did not enter execute");

	a_exec_wb: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == tssb_pkg::S_EXEC) |=> (state_q == tssb_pkg::S_WB))
		else $error("execute not followed by writeback");

	// A push never steps a full counter past the depth
	a_no_overfill: assert property (@(posedge clk) disable iff (!arst_n)
		(fill_cmd.commit && fill_cmd.up) |-> (sel_fill < FILL_W'(STACK_DEPTH)))
		else $error("push committed on a full stack");

	// A pop never steps an empty counter below zero
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		(fill_cmd.commit && !fill_cmd.up) |-> (sel_fill != '0))
		else $error("pop committed on an empty stack");

endmodule
